@@ hdl/utcl_pkg.sv @@
// Shared types, codes and calendar helpers for the UTC to local time pipeline.
// No dependencies; imported by every module of the block but the port checker.
`timescale 1ns / 1ps
`default_nettype none

package utcl_pkg;

  // Month codes
  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthMar = 4'd3;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  // Configuration register indexes
  localparam logic CfgZoneOffset = 1'b0;
  localparam logic CfgDstEnable  = 1'b1;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // Raw request and zone-stage result
  typedef struct packed {
    date_t      date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [7:0] delay;
  } zone_t;

  // Result of the middle stages: minute/second done, DST key prepared
  typedef struct packed {
    date_t      date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       min_carry;
    logic [6:0] wkey;
    logic [4:0] wq;
    logic [5:0] second;
  } mid_t;

  typedef struct packed {
    date_t      date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       dst;
  } local_t;

  // Days in a month, leap year every fourth year
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic [11:0] year);
    logic [4:0] len;
    case (month)
      MonthFeb: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Advance one day, a day at or past month end rolls to the next month
  function automatic date_t next_date(input date_t cur);
    date_t nd;
    nd = cur;
    if (cur.day >= month_len(cur.month, cur.year)) begin
      nd.day = 5'd1;
      if (cur.month >= MonthDec) begin
        nd.month = MonthJan;
        nd.year  = cur.year + 12'd1;
      end else begin
        nd.month = cur.month + 4'd1;
      end
    end else begin
      nd.day = cur.day + 5'd1;
    end
    return nd;
  endfunction

endpackage

`default_nettype wire

@@ hdl/utcl_zone.sv @@
// Zone stage: clamps month/day and applies the signed zone offset to the hour,
// moving the date back or forward one day. Depends on utcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utcl_zone
  import utcl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic signed [4:0] zone_offset,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire zone_t             in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output zone_t                  out_data
);

  date_t             clean;
  date_t             prev;
  date_t             fwd;
  zone_t             zone_next;
  logic signed [6:0] hsum;
  logic signed [6:0] hup;
  logic signed [6:0] hdn;

  // Clamp out-of-range month and day
  always_comb begin
    clean.year  = in_data.date.year;
    if (in_data.date.month == 4'd0) begin
      clean.month = MonthJan;
    end else if (in_data.date.month > MonthDec) begin
      clean.month = MonthDec;
    end else begin
      clean.month = in_data.date.month;
    end
    clean.day = (in_data.date.day == 5'd0) ? 5'd1 : in_data.date.day;
  end

  // Previous day, borrowing into month and year
  always_comb begin
    prev = clean;
    if (clean.day == 5'd1) begin
      if (clean.month <= MonthJan) begin
        prev.month = MonthDec;
        prev.year  = clean.year - 12'd1;
      end else begin
        prev.month = clean.month - 4'd1;
      end
      prev.day = month_len(prev.month, prev.year);
    end else begin
      prev.day = clean.day - 5'd1;
    end
  end

  assign fwd  = next_date(clean);
  assign hsum = $signed({2'b00, in_data.hour}) + $signed({{2{zone_offset[4]}}, zone_offset});
  assign hup  = hsum + 7'sd24;
  assign hdn  = hsum - 7'sd24;

  // Hour wrap and date select
  always_comb begin
    zone_next = in_data;
    if (hsum < 7'sd1) begin
      if (hup == 7'sd24) begin
        zone_next.hour = 5'd0;
        zone_next.date = clean;
      end else begin
        zone_next.hour = hup[4:0];
        zone_next.date = prev;
      end
    end else if (hsum > 7'sd23) begin
      zone_next.hour = hdn[4:0];
      zone_next.date = fwd;
    end else begin
      zone_next.hour = hsum[4:0];
      zone_next.date = clean;
    end
  end

  // Stage register
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= zone_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/utcl_mid.sv @@
// Middle stages: year mod 100 by reciprocal, second and minute carries, and the
// weekday key for the DST start day. Three register stages. Depends on utcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utcl_mid
  import utcl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire zone_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output mid_t      out_data
);

  typedef struct packed {
    date_t      date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] sec_carry;
    logic [5:0] q100;
  } stb_t;

  typedef struct packed {
    date_t      date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       min_carry;
    logic [6:0] wkey;
    logic [5:0] second;
  } stc_t;

  stb_t        b_q;
  stb_t        b_next;
  stc_t        c_q;
  stc_t        c_next;
  mid_t        d_next;
  logic        b_vld;
  logic        c_vld;
  logic        b_rdy;
  logic        c_rdy;
  logic [24:0] yprod;
  logic [8:0]  tsec;
  logic [2:0]  cs;
  logic [8:0]  srem;
  logic [11:0] yrem;
  logic [6:0]  yy;
  logic [6:0]  tmin;
  logic [14:0] wprod;

  // Stage B: year / 100 by reciprocal multiply, seconds plus delay
  assign yprod = 25'(in_data.date.year) * 25'd5243;
  assign tsec  = 9'(in_data.second) + 9'(in_data.delay);

  always_comb begin
    if (tsec >= 9'd300) begin
      cs = 3'd5;
    end else if (tsec >= 9'd240) begin
      cs = 3'd4;
    end else if (tsec >= 9'd180) begin
      cs = 3'd3;
    end else if (tsec >= 9'd120) begin
      cs = 3'd2;
    end else if (tsec >= 9'd60) begin
      cs = 3'd1;
    end else begin
      cs = 3'd0;
    end
  end

  assign srem = tsec - 9'(cs) * 9'd60;

  always_comb begin
    b_next.date      = in_data.date;
    b_next.hour      = in_data.hour;
    b_next.minute    = in_data.minute;
    b_next.second    = srem[5:0];
    b_next.sec_carry = cs;
    b_next.q100      = yprod[24:19];
  end

  // Stage C: year mod 100, weekday key, minute carry
  assign yrem = b_q.date.year - 12'(b_q.q100) * 12'd100;
  assign yy   = yrem[6:0];
  assign tmin = 7'(b_q.minute) + 7'(b_q.sec_carry);

  always_comb begin
    c_next.date      = b_q.date;
    c_next.hour      = b_q.hour;
    c_next.second    = b_q.second;
    c_next.wkey      = yy + {2'b00, yy[6:2]} + 7'd2;
    c_next.min_carry = (tmin >= 7'd60);
    if (tmin >= 7'd60) begin
      c_next.minute = 6'(tmin - 7'd60);
    end else begin
      c_next.minute = tmin[5:0];
    end
  end

  // Stage D: key / 7 by reciprocal multiply
  assign wprod = 15'(c_q.wkey) * 15'd147;

  always_comb begin
    d_next.date      = c_q.date;
    d_next.hour      = c_q.hour;
    d_next.minute    = c_q.minute;
    d_next.min_carry = c_q.min_carry;
    d_next.wkey      = c_q.wkey;
    d_next.wq        = wprod[14:10];
    d_next.second    = c_q.second;
  end

  // Stage handshakes, ready flows back per stage
  assign c_rdy    = !out_valid || out_ready;
  assign b_rdy    = !c_vld || c_rdy;
  assign in_ready = !b_vld || b_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        b_vld <= in_valid;
      end
      if (b_rdy) begin
        c_vld <= b_vld;
      end
      if (c_rdy) begin
        out_valid <= c_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      b_q <= b_next;
    end
    if (b_rdy) begin
      c_q <= c_next;
    end
    if (c_rdy) begin
      out_data <= d_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/utcl_final.sv @@
// Final stages: DST window decision, hour carry, then the day advance from the
// hour carry. Two register stages, the last is the output register. Depends on utcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utcl_final
  import utcl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic dst_enable,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire mid_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output local_t    out_data
);

  typedef struct packed {
    date_t      date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       dst;
    logic       day_carry;
  } ste_t;

  ste_t       e_q;
  ste_t       e_next;
  local_t     f_next;
  logic       e_vld;
  logic       e_rdy;
  logic [6:0] wrem;
  logic [3:0] start_day;
  logic       act;
  logic [4:0] thour;

  // Stage E: second-Sunday start day and window test
  assign wrem      = in_data.wkey - 7'(in_data.wq) * 7'd7;
  assign start_day = 4'd14 - {1'b0, wrem[2:0]};

  always_comb begin
    act = 1'b0;
    if (dst_enable) begin
      if (in_data.date.month == MonthMar) begin
        act = (in_data.date.day > 5'(start_day)) ||
              ((in_data.date.day == 5'(start_day)) && (in_data.hour > 5'd1));
      end else if ((in_data.date.month > MonthMar) && (in_data.date.month < MonthNov)) begin
        act = 1'b1;
      end
    end
  end

  // Hour plus DST hour plus minute carry
  assign thour = in_data.hour + 5'(act) + 5'(in_data.min_carry);

  always_comb begin
    e_next.date      = in_data.date;
    e_next.minute    = in_data.minute;
    e_next.second    = in_data.second;
    e_next.dst       = act;
    e_next.day_carry = (thour >= 5'd24);
    if (thour >= 5'd24) begin
      e_next.hour = thour - 5'd24;
    end else begin
      e_next.hour = thour;
    end
  end

  // Stage F: day advance on hour carry
  always_comb begin
    f_next.date   = e_q.day_carry ? next_date(e_q.date) : e_q.date;
    f_next.hour   = e_q.hour;
    f_next.minute = e_q.minute;
    f_next.second = e_q.second;
    f_next.dst    = e_q.dst;
  end

  assign e_rdy    = !out_valid || out_ready;
  assign in_ready = !e_vld || e_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        e_vld <= in_valid;
      end
      if (e_rdy) begin
        out_valid <= e_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      e_q <= e_next;
    end
    if (e_rdy) begin
      out_data <= f_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/utc_to_local_time_with_dst.sv @@
// UTC to local time with US daylight saving, top level.
// Register stages from request accept to result valid: zone, 3 middle, 2 final.
// Throughput: one request per cycle; each stage holds under backpressure and
// takes a new request as soon as its own register is free.
// Reset (rst, synchronous): all stage valid bits clear, zone_offset = 0, dst_enable = 1.
// Depends on utcl_pkg, utcl_zone, utcl_mid, utcl_final.
`timescale 1ns / 1ps
`default_nettype none

module utc_to_local_time_with_dst
  import utcl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [4:0]  cfg_data,
  // Request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // low to high: utc_year[11:0], utc_month[15:12], utc_day[20:16], utc_hour[25:21],
  // utc_minute[31:26], utc_second[37:32], delay_seconds[45:38], zero pad[47:46]
  input  wire logic [47:0] s_tdata,
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // low to high: local_year[11:0], local_month[15:12], local_day[20:16], local_hour[25:21],
  // local_minute[31:26], local_second[37:32], zero pad[39:38]
  output logic [39:0]      m_tdata,
  // dst_active[0]
  output logic             m_tuser
);

  logic signed [4:0] zone_offset;
  logic              dst_enable;
  zone_t             req;
  zone_t             zone_q;
  mid_t              mid_q;
  local_t            res;
  logic              zone_vld;
  logic              zone_rdy;
  logic              mid_vld;
  logic              mid_rdy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= 5'sd0;
      dst_enable  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgZoneOffset: zone_offset <= $signed(cfg_data);
        CfgDstEnable:  dst_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack request
  always_comb begin
    req.date.year  = s_tdata[11:0];
    req.date.month = s_tdata[15:12];
    req.date.day   = s_tdata[20:16];
    req.hour       = s_tdata[25:21];
    req.minute     = s_tdata[31:26];
    req.second     = s_tdata[37:32];
    req.delay      = s_tdata[45:38];
  end

  utcl_zone u_zone (
    .clk         (clk),
    .rst         (rst),
    .zone_offset (zone_offset),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_data     (req),
    .out_valid   (zone_vld),
    .out_ready   (zone_rdy),
    .out_data    (zone_q)
  );

  utcl_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (zone_vld),
    .in_ready  (zone_rdy),
    .in_data   (zone_q),
    .out_valid (mid_vld),
    .out_ready (mid_rdy),
    .out_data  (mid_q)
  );

  utcl_final u_final (
    .clk        (clk),
    .rst        (rst),
    .dst_enable (dst_enable),
    .in_valid   (mid_vld),
    .in_ready   (mid_rdy),
    .in_data    (mid_q),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (res)
  );

  // Pack result
  assign m_tdata = {2'b00, res.second, res.minute, res.hour,
                    res.date.day, res.date.month, res.date.year};
  assign m_tuser = res.dst;

endmodule

`default_nettype wire

@@ hdl/utcl_checker.sv @@
// Port-level checks for the UTC to local time block, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module utcl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic        cfg_addr,
  input wire logic [4:0]  cfg_data,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [47:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser
);

  // No result the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // Carried fields always land in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12) &&
                  (m_tdata[20:16] != 5'd0) && (m_tdata[25:21] <= 5'd23) &&
                  (m_tdata[31:26] <= 6'd59) && (m_tdata[37:32] <= 6'd59) &&
                  (m_tdata[39:38] == 2'b00)))
    else $error("result field out of range");

  // DST hour only between March and the November 1 carry
  a_dst_window: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> ((m_tdata[15:12] >= 4'd3) && (m_tdata[15:12] <= 4'd11)))
    else $error("dst hour outside its window");

endmodule

bind utc_to_local_time_with_dst utcl_checker u_utcl_checker (.*);

`default_nettype wire

@@ bench/local_time_checker.sv @@
// Checker for the UTC to local time block: predicts each local timestamp from the
// accepted requests and its own copy of the zone/DST registers, then compares results.
// Depends on utcl_pkg for the register indexes, month codes and the result struct.
`timescale 1ns / 1ps

module local_time_checker
  import utcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  output int          mismatch_count,
  output int          in_flight
);

  int     zone_hours;
  logic   dst_on;
  local_t awaited[$];

  function automatic int unsigned days_in(input int unsigned mon, input int unsigned yr);
    if (mon == MonthFeb) return (yr % 4 == 0) ? 29 : 28;
    if (mon == MonthApr || mon == MonthJun || mon == MonthSep || mon == MonthNov) return 30;
    return 31;
  endfunction

  // One day forward; a day at or past month end starts the next month
  function automatic void roll_day(inout int unsigned yr, inout int unsigned mo,
                                   inout int unsigned dy);
    if (dy >= days_in(mo, yr)) begin
      dy = 1;
      if (mo >= MonthDec) begin
        mo = MonthJan;
        yr = (yr + 1) & 'hFFF;
      end else begin
        mo = mo + 1;
      end
    end else begin
      dy = dy + 1;
    end
  endfunction

  function automatic local_t predict_local(input logic [45:0] req, input int offset,
                                           input logic dst_rule);
    int unsigned yr, mo, dy, hu, mi, se, dl, t, yy, second_sunday;
    int          hr;
    logic        act;
    local_t      r;
    yr = req[11:0];
    mo = req[15:12];
    dy = req[20:16];
    hr = req[25:21];
    mi = req[31:26];
    se = req[37:32];
    dl = req[45:38];
    if (mo == 0) mo = MonthJan;
    if (mo > MonthDec) mo = MonthDec;
    if (dy == 0) dy = 1;

    // zone shift, at most one day either way; landing on hour 0 keeps the date
    hr = hr + offset;
    if (hr < 1) begin
      hr = hr + 24;
      if (hr == 24) begin
        hr = 0;
      end else begin
        dy = dy - 1;
        if (dy == 0) begin
          if (mo <= MonthJan) begin
            mo = MonthDec;
            yr = (yr - 1) & 'hFFF;
          end else begin
            mo = mo - 1;
          end
          dy = days_in(mo, yr);
        end
      end
    end else if (hr > 23) begin
      hr = hr - 24;
      roll_day(yr, mo, dy);
    end
    hu = hr;

    // US window: second Sunday of March from 02:00 standard, through October
    act = 1'b0;
    if (dst_rule) begin
      yy = yr % 100;
      second_sunday = 14 - (yy + yy / 4 + 2) % 7;
      if ((mo == MonthMar && (dy > second_sunday || (dy == second_sunday && hu > 1))) ||
          (mo > MonthMar && mo < MonthNov))
        act = 1'b1;
    end
    hu = hu + act;

    // delay added with carry through to the date
    t  = se + dl;
    se = t % 60;
    t  = mi + t / 60;
    mi = t % 60;
    t  = hu + t / 60;
    hu = t % 24;
    if (t >= 24) roll_day(yr, mo, dy);

    r.date.year  = 12'(yr);
    r.date.month = 4'(mo);
    r.date.day   = 5'(dy);
    r.hour       = 5'(hu);
    r.minute     = 6'(mi);
    r.second     = 6'(se);
    r.dst        = act;
    return r;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Sampled at the rising edge: results first, then new requests, then register writes
  always @(posedge clk) begin : watch
    local_t got, want;
    if (rst) begin
      zone_hours = 0;
      dst_on     = 1'b1;
      awaited.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.date.year  = m_tdata[11:0];
        got.date.month = m_tdata[15:12];
        got.date.day   = m_tdata[20:16];
        got.hour       = m_tdata[25:21];
        got.minute     = m_tdata[31:26];
        got.second     = m_tdata[37:32];
        got.dst        = m_tuser;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h/%b", $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          want = awaited.pop_front();
          check_field("local_year", want.date.year, got.date.year);
          check_field("local_month", want.date.month, got.date.month);
          check_field("local_day", want.date.day, got.date.day);
          check_field("local_hour", want.hour, got.hour);
          check_field("local_minute", want.minute, got.minute);
          check_field("local_second", want.second, got.second);
          check_field("dst_active", want.dst, got.dst);
        end
      end
      if (s_tvalid && s_tready)
        awaited.push_back(predict_local(s_tdata[45:0], zone_hours, dst_on));
      if (cfg_we) begin
        if (cfg_addr == CfgZoneOffset) zone_hours = int'($signed(cfg_data));
        else dst_on = cfg_data[0];
      end
    end
    in_flight = awaited.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the UTC to local time bench: clock, reset, register settings, request
// stimulus with random gaps and backpressure, watchdog and verdict.
// Depends on utcl_pkg, utc_to_local_time_with_dst and local_time_checker.
`timescale 1ns / 1ps

module tb_top;
  import utcl_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 66;
  localparam int MonthOct       = 10;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_addr;
  logic [4:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  int          mismatch_count;
  int          in_flight;
  int          idle_cycles;
  bit          calm;
  bit          stall_now;

  utc_to_local_time_with_dst dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  local_time_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .in_flight      (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request payload, year in the low bits
  function automatic logic [45:0] pack_stamp(input int yr, input int mo, input int dy,
                                             input int hr, input int mi, input int se,
                                             input int dl);
    return {8'(dl), 6'(se), 6'(mi), 5'(hr), 5'(dy), 4'(mo), 12'(yr)};
  endfunction

  // Mostly valid dates, biased toward day/month/year boundaries and the DST boundaries
  function automatic logic [45:0] random_stamp();
    int yr, mo, dy, hr, mi, se, dl, kind, last;
    kind = $urandom_range(0, 99);
    yr   = $urandom_range(2000, 2099);
    mo   = $urandom_range(1, 12);
    last = (mo == MonthFeb) ? ((yr % 4 == 0) ? 29 : 28) :
           (mo == MonthApr || mo == MonthJun || mo == MonthSep || mo == MonthNov) ? 30 : 31;
    dy   = $urandom_range(1, last);
    hr   = $urandom_range(0, 23);
    mi   = $urandom_range(0, 59);
    se   = $urandom_range(0, 59);
    dl   = $urandom_range(0, 255);
    if (kind < 15) begin
      // raw noise over the full field widths
      yr = $urandom_range(0, 4095);
      mo = $urandom_range(0, 15);
      dy = $urandom_range(0, 31);
      hr = $urandom_range(0, 31);
      mi = $urandom_range(0, 63);
      se = $urandom_range(0, 63);
    end else if (kind < 40) begin
      dy = ($urandom_range(0, 1) != 0) ? last : 1;
      hr = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(19, 23);
      mi = $urandom_range(50, 59);
    end else if (kind < 55) begin
      mo = MonthMar;
      dy = $urandom_range(7, 15);
    end else if (kind < 62) begin
      if ($urandom_range(0, 1) != 0) begin
        mo = MonthOct;
        dy = 31;
      end else begin
        mo = MonthNov;
        dy = 1;
      end
    end else if (kind < 67) begin
      if ($urandom_range(0, 1) != 0) begin
        mo = MonthDec;
        dy = 31;
        hr = $urandom_range(12, 23);
      end else begin
        mo = MonthJan;
        dy = 1;
        hr = $urandom_range(0, 11);
      end
      if ($urandom_range(0, 2) == 0) yr = ($urandom_range(0, 1) != 0) ? 4095 : 0;
    end
    return pack_stamp(yr, mo, dy, hr, mi, se, dl);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm || stall_now) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request and hold it until it is taken
  task automatic offer(input logic [45:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, stamp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Wait for every outstanding result, then let the pipeline drain
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Both registers, one per cycle; spare data bits of the DST write are junk
  task automatic apply_setting(input logic [4:0] offset, input logic dst);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= CfgZoneOffset;
    cfg_data <= offset;
    @(negedge clk);
    cfg_addr <= CfgDstEnable;
    cfg_data <= {4'($urandom), dst};
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Result side: random ready, occasional long stalls, one forced long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_now) begin
        m_tready <= 1'b0;
        repeat (120) @(negedge clk);
        stall_now = 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    int   zone_set[8];
    logic dst_set[8];
    logic [4:0] zone;
    zone_set  = '{-12, 14, 15, -16, 0, 7, -3, 0};
    dst_set   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = CfgZoneOffset;
    cfg_data  = 5'd0;
    s_tvalid  = 1'b0;
    s_tdata   = 48'd0;
    calm      = 1'b0;
    stall_now = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed, zone behind UTC: borrows, leap Feb, zone hour zero, DST boundaries
    apply_setting(5'(-5), 1'b1);
    offer(pack_stamp(2000, 1, 1, 0, 0, 0, 0));
    offer(pack_stamp(0, 1, 1, 3, 0, 0, 0));
    offer(pack_stamp(2024, 3, 1, 2, 0, 0, 0));
    offer(pack_stamp(2023, 3, 1, 2, 0, 0, 0));
    offer(pack_stamp(2024, 5, 10, 5, 30, 0, 0));
    offer(pack_stamp(2024, 3, 10, 6, 59, 59, 0));
    offer(pack_stamp(2024, 3, 10, 7, 0, 0, 0));
    offer(pack_stamp(2024, 3, 9, 20, 0, 0, 0));
    offer(pack_stamp(2024, 3, 11, 12, 0, 0, 0));
    offer(pack_stamp(2024, 11, 5, 12, 0, 0, 0));
    offer(pack_stamp(2024, 10, 31, 23, 0, 0, 0));
    offer(pack_stamp(2050, 0, 15, 10, 0, 0, 0));
    offer(pack_stamp(2050, 15, 15, 10, 0, 0, 0));
    offer(pack_stamp(2050, 2, 0, 10, 0, 0, 0));
    offer(pack_stamp(2023, 4, 31, 4, 0, 0, 0));
    offer(pack_stamp(2050, 6, 30, 31, 63, 63, 255));
    settle();

    // Directed, zone ahead of UTC: year end, year wrap, delay carry into a new year
    apply_setting(5'd14, 1'b1);
    offer(pack_stamp(2099, 12, 31, 20, 0, 0, 0));
    offer(pack_stamp(4095, 12, 31, 12, 0, 0, 0));
    offer(pack_stamp(2023, 2, 28, 23, 59, 59, 255));
    offer(pack_stamp(2050, 2, 31, 15, 0, 0, 0));
    offer(pack_stamp(2024, 12, 31, 9, 59, 59, 255));
    offer(pack_stamp(2024, 3, 9, 12, 0, 0, 0));
    offer(pack_stamp(2024, 10, 31, 10, 59, 0, 60));
    offer(pack_stamp(2031, 7, 4, 5, 30, 30, 128));
    settle();

    // Random phases over several register settings
    for (int p = 0; p < 8; p++) begin
      zone = (p == 7) ? 5'($urandom_range(0, 31)) : 5'(zone_set[p]);
      apply_setting(zone, (p == 7) ? 1'($urandom_range(0, 1)) : dst_set[p]);
      calm = (p == 5);
      if (p == 1) stall_now = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) offer(random_stamp());
      settle();
    end
    calm = 1'b0;

    if (mismatch_count == 0 && in_flight == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
